/* sv/ecst_pkg.sv */
// Package for the epoch-checked surface table: operation kinds, status codes,
// entry states and the register map. No dependencies.
package ecst_pkg;
  localparam logic [3:0] K_REGISTER = 4'd0;
  localparam logic [3:0] K_CLOSE = 4'd1;
  localparam logic [3:0] K_RESIZE = 4'd2;
  localparam logic [3:0] K_PRESENT_STORED = 4'd3;
  localparam logic [3:0] K_PRESENT = 4'd4;
  localparam logic [3:0] K_BACKPRESSURE = 4'd5;
  localparam logic [3:0] K_LOST = 4'd6;
  localparam logic [3:0] K_SWONLY = 4'd7;
  localparam logic [3:0] K_REPROJECT = 4'd8;
  localparam logic [3:0] K_FALLBACK = 4'd9;
  localparam logic [3:0] K_FAIL = 4'd10;
  localparam logic [3:0] K_READ = 4'd11;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_BUSY = 3'd3;
  localparam logic [2:0] ST_STALE = 3'd4;
  localparam logic [2:0] ST_UNKNOWN = 3'd5;
  localparam logic [2:0] ST_CLOSED = 3'd6;

  localparam logic [2:0] S_CLOSED = 3'd0;
  localparam logic [2:0] S_READY = 3'd1;
  localparam logic [2:0] S_BACKPRESSURE = 3'd2;
  localparam logic [2:0] S_LOST = 3'd3;
  localparam logic [2:0] S_SWONLY = 3'd4;
  localparam logic [2:0] S_FALLBACK = 3'd5;
  localparam logic [2:0] S_FAILED = 3'd6;

  localparam logic [0:0] REG_MAX_SURFACES = 1'b0;

  localparam int InWidth = 4 + 32 + 64 * 4 + 32 + 32 + 1 + 1;
  localparam int InBytes = (InWidth + 7) / 8;
  localparam int OutWidth = 3 + 3 + 1 + 64 * 3 + 32 + 32 + 64 + 1 + 1;
  localparam int OutBytes = (OutWidth + 7) / 8;
endpackage

/* sv/epoch_checked_surface_table_unit.sv */
// Surface table with epoch checks: key search, checks and entry update.
// Depends on ecst_pkg.
//
// A shared key comparator walks one slot a cycle through all ENTRIES slots,
// the EXEC state checks and updates the entry, and the result then sits in
// an output register. The next item is taken in the idle state after the
// result has left (an output stall delays this), so no new item is taken
// before the last one is through.
// Reset clears valid bits, fill count and max_surfaces=16.
module epoch_checked_surface_table_unit #(
  parameter int ENTRIES = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // kind, surface_id, lifetime_epoch, device_epoch, layout_epoch, request_id,
  // width, height, visible, software_only (lowest bit up)
  input  logic [ecst_pkg::InBytes*8-1:0] s_axis_tdata_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // status, entry_state, entry_found, out_lifetime_epoch, out_device_epoch,
  // out_layout_epoch, out_width, out_height, out_last_request, out_visible,
  // out_has_content (lowest bit up)
  output logic [ecst_pkg::OutBytes*8-1:0] m_axis_tdata_o,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import ecst_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  localparam logic [1:0] FSM_IDLE = 2'd0;
  localparam logic [1:0] FSM_SCAN = 2'd1;
  localparam logic [1:0] FSM_EXEC = 2'd2;
  localparam logic [1:0] FSM_OUT = 2'd3;

  logic [1:0] fsm_q, fsm_d;
  logic [4:0] max_q;
  logic [CW-1:0] used_cnt_q;
  logic [ENTRIES-1:0] used_q;
  logic [IW-1:0] scan_q;
  logic hit_q;
  logic [IW-1:0] hit_idx_q;
  logic [InWidth-1:0] in_q;
  logic [OutWidth-1:0] out_q;

  logic [31:0] key_mem [ENTRIES];
  logic [63:0] life_mem [ENTRIES];
  logic [63:0] dev_mem [ENTRIES];
  logic [63:0] lay_mem [ENTRIES];
  logic [31:0] w_mem [ENTRIES];
  logic [31:0] h_mem [ENTRIES];
  logic [2:0] stat_mem [ENTRIES];
  logic [63:0] req_mem [ENTRIES];
  logic vis_mem [ENTRIES];
  logic cont_mem [ENTRIES];

  // Unpack the held input item.
  logic [3:0] kind;
  logic [31:0] id, w, h;
  logic [63:0] life, dev, lay, req;
  logic vis, sw;
  assign kind = in_q[3:0];
  assign id = in_q[35:4];
  assign life = in_q[99:36];
  assign dev = in_q[163:100];
  assign lay = in_q[227:164];
  assign req = in_q[291:228];
  assign w = in_q[323:292];
  assign h = in_q[355:324];
  assign vis = in_q[356];
  assign sw = in_q[357];

  assign s_axis_tready_o = (fsm_q == FSM_IDLE);
  assign m_axis_tvalid_o = (fsm_q == FSM_OUT);
  assign m_axis_tdata_o = {{(OutBytes*8-OutWidth){1'b0}}, out_q};
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_SURFACES) ? {27'd0, max_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= 5'd16;
    end else if (psel && penable && pwrite && paddr[2] == REG_MAX_SURFACES) begin
      max_q <= pwdata[4:0];
    end
  end

  // Limit: zero acts as one, above ENTRIES acts as ENTRIES.
  logic [5:0] lim;
  always_comb begin
    lim = (max_q == 5'd0) ? 6'd1 : {1'b0, max_q};
    if (32'(lim) > ENTRIES) lim = 6'(ENTRIES);
  end

  // Entry read at the hit slot.
  logic [63:0] e_life, e_dev, e_lay, e_req;
  logic [2:0] e_st;
  assign e_life = life_mem[hit_idx_q];
  assign e_dev = dev_mem[hit_idx_q];
  assign e_lay = lay_mem[hit_idx_q];
  assign e_req = req_mem[hit_idx_q];
  assign e_st = stat_mem[hit_idx_q];

  // Decision for the EXEC cycle.
  logic [2:0] st, se;
  logic do_fill, new_slot, wr_stat, wr_size, wr_pres, wr_dev, wr_vis;
  logic [2:0] n_stat;
  logic n_vis;
  logic [63:0] p_lay;
  logic chk_ok;
  logic [2:0] chk_st, chk_se;

  always_comb begin
    chk_se = S_CLOSED;
    chk_ok = 1'b0;
    if (id == 32'd0 || life == 64'd0) chk_st = ST_INVALID;
    else if (!hit_q) chk_st = ST_UNKNOWN;
    else begin
      chk_se = e_st;
      if (e_life != life) chk_st = ST_STALE;
      else if (e_st == S_CLOSED) chk_st = ST_CLOSED;
      else begin
        chk_st = ST_OK;
        chk_ok = 1'b1;
      end
    end
  end

  always_comb begin
    st = ST_INVALID;
    se = S_CLOSED;
    do_fill = 1'b0;
    new_slot = 1'b0;
    wr_stat = 1'b0;
    wr_size = 1'b0;
    wr_pres = 1'b0;
    wr_dev = 1'b0;
    wr_vis = 1'b0;
    n_stat = S_READY;
    n_vis = 1'b0;
    p_lay = lay;
    unique case (kind)
      K_REGISTER: begin
        if (id != 0 && life != 0 && dev != 0 && lay != 0 && w != 0 && h != 0) begin
          if (!hit_q) begin
            if ({1'b0, used_cnt_q} >= (CW+1)'(lim)) st = ST_FULL;
            else begin
              st = ST_OK;
              se = S_READY;
              do_fill = 1'b1;
              new_slot = 1'b1;
            end
          end else begin
            se = e_st;
            if (e_life == life) st = (e_st != S_CLOSED) ? ST_BUSY : ST_STALE;
            else if (life < e_life) st = ST_STALE;
            else begin
              st = ST_OK;
              se = S_READY;
              do_fill = 1'b1;
            end
          end
        end
      end
      K_CLOSE, K_BACKPRESSURE, K_FAIL: begin
        st = chk_st;
        se = chk_se;
        if (chk_ok) begin
          wr_stat = 1'b1;
          n_stat = (kind == K_CLOSE) ? S_CLOSED :
                   (kind == K_BACKPRESSURE) ? S_BACKPRESSURE : S_FAILED;
          wr_vis = (kind == K_CLOSE);
          se = n_stat;
        end
      end
      K_RESIZE: begin
        if (w != 0 && h != 0) begin
          st = chk_st;
          se = chk_se;
          wr_size = chk_ok;
        end
      end
      K_PRESENT_STORED, K_PRESENT, K_FALLBACK: begin
        if (kind == K_PRESENT_STORED && !chk_ok) begin
          st = chk_st;
          se = chk_se;
        end else begin
          if (kind == K_PRESENT_STORED) p_lay = e_lay;
          if (dev == 0 || p_lay == 0 || req == 0) begin
            st = ST_INVALID;
            se = S_CLOSED;
          end else begin
            st = chk_st;
            se = chk_se;
            if (chk_ok) begin
              if (dev != e_dev || p_lay < e_lay || req <= e_req) st = ST_STALE;
              else begin
                wr_pres = 1'b1;
                wr_stat = 1'b1;
                n_stat = (kind == K_FALLBACK) ? S_FALLBACK : S_READY;
                wr_vis = (kind == K_FALLBACK);
                n_vis = vis;
                se = n_stat;
              end
            end
          end
        end
      end
      K_LOST, K_SWONLY, K_REPROJECT: begin
        if (dev != 0) begin
          st = chk_st;
          se = chk_se;
          if (chk_ok) begin
            if ((kind == K_REPROJECT) ? (dev <= e_dev) : (dev < e_dev)) st = ST_STALE;
            else begin
              wr_dev = 1'b1;
              wr_stat = 1'b1;
              if (kind == K_LOST) n_stat = S_LOST;
              else if (kind == K_SWONLY) n_stat = S_SWONLY;
              else if (e_st == S_FALLBACK) n_stat = S_FALLBACK;
              else n_stat = sw ? S_SWONLY : S_READY;
              se = n_stat;
            end
          end
        end
      end
      K_READ: begin
        if (hit_q) begin
          st = ST_OK;
          se = e_st;
        end else st = ST_UNKNOWN;
      end
      default: ;
    endcase
  end

  logic [IW-1:0] wi;
  assign wi = new_slot ? used_cnt_q[IW-1:0] : hit_idx_q;

  // Snapshot after the step, built from the written values.
  logic found;
  logic [63:0] o_life, o_dev, o_lay, o_req;
  logic [31:0] o_w, o_h;
  logic o_vis, o_cont;
  always_comb begin
    found = hit_q || do_fill;
    o_life = life_mem[wi];
    o_dev = dev_mem[wi];
    o_lay = lay_mem[wi];
    o_req = req_mem[wi];
    o_w = w_mem[wi];
    o_h = h_mem[wi];
    o_vis = vis_mem[wi];
    o_cont = cont_mem[wi];
    if (do_fill) begin
      o_life = life; o_dev = dev; o_lay = lay; o_req = 64'd0;
      o_w = w; o_h = h; o_vis = vis; o_cont = 1'b0;
    end
    if (wr_size) begin o_w = w; o_h = h; end
    if (wr_pres) begin o_lay = p_lay; o_req = req; o_cont = 1'b1; end
    if (wr_dev) o_dev = dev;
    if (wr_vis) o_vis = n_vis;
    if (!found) begin
      o_life = '0; o_dev = '0; o_lay = '0; o_req = '0;
      o_w = '0; o_h = '0; o_vis = 1'b0; o_cont = 1'b0;
    end
  end

  always_comb begin
    fsm_d = fsm_q;
    unique case (fsm_q)
      FSM_IDLE: if (s_axis_tvalid_i) fsm_d = FSM_SCAN;
      FSM_SCAN: if (32'(scan_q) == ENTRIES - 1) fsm_d = FSM_EXEC;
      FSM_EXEC: fsm_d = FSM_OUT;
      FSM_OUT:  if (m_axis_tready_i) fsm_d = FSM_IDLE;
      default:  fsm_d = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q <= FSM_IDLE;
      used_q <= '0;
      used_cnt_q <= '0;
      scan_q <= '0;
      hit_q <= 1'b0;
    end else begin
      fsm_q <= fsm_d;
      if (fsm_q == FSM_IDLE && s_axis_tvalid_i) begin
        scan_q <= '0;
        hit_q <= 1'b0;
      end
      // Advance the shared comparator one slot per cycle.
      if (fsm_q == FSM_SCAN) begin
        if (id != 0 && used_q[scan_q] && key_mem[scan_q] == id && !hit_q) begin
          hit_q <= 1'b1;
        end
        scan_q <= scan_q + 1'b1;
      end
      if (fsm_q == FSM_EXEC && new_slot) begin
        used_q[wi] <= 1'b1;
        used_cnt_q <= used_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fsm_q == FSM_IDLE && s_axis_tvalid_i) in_q <= s_axis_tdata_i[InWidth-1:0];
    if (fsm_q == FSM_SCAN && id != 0 && used_q[scan_q] && key_mem[scan_q] == id && !hit_q)
      hit_idx_q <= scan_q;
    if (fsm_q == FSM_EXEC) begin
      out_q <= {o_cont, o_vis, o_req, o_h, o_w, o_lay, o_dev, o_life, found, se, st};
      if (do_fill) begin
        key_mem[wi] <= id;
        life_mem[wi] <= life;
        dev_mem[wi] <= dev;
        lay_mem[wi] <= lay;
        w_mem[wi] <= w;
        h_mem[wi] <= h;
        stat_mem[wi] <= S_READY;
        req_mem[wi] <= 64'd0;
        vis_mem[wi] <= vis;
        cont_mem[wi] <= 1'b0;
      end
      if (wr_stat) stat_mem[wi] <= n_stat;
      if (wr_size) begin
        w_mem[wi] <= w;
        h_mem[wi] <= h;
      end
      if (wr_pres) begin
        lay_mem[wi] <= p_lay;
        req_mem[wi] <= req;
        cont_mem[wi] <= 1'b1;
      end
      if (wr_dev) dev_mem[wi] <= dev;
      if (wr_vis) vis_mem[wi] <= n_vis;
    end
  end
endmodule
